// File: rtl/core/lpd_pkg.sv
`timescale 1ns / 1ps

package lpd_pkg;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_HEAD,
      PH_COUNT,
      PH_OFFSET,
      PH_RETURN,
      PH_POINT,
      PH_TAIL
   } phase_type;

   // record kinds
   localparam logic [1:0] KIND_FIELD = 2'd0;
   localparam logic [1:0] KIND_POINT = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // field codes of the roll and tail records
   localparam logic [5:0] CODE_NONE        = 6'd0;
   localparam logic [5:0] CODE_CHAN_COUNT  = 6'd32;
   localparam logic [5:0] CODE_TIME_OFFSET = 6'd33;
   localparam logic [5:0] CODE_RETURN_NUM  = 6'd34;
   localparam logic [5:0] CODE_TAIL        = 6'd35;

   // byte positions inside the header (sync word occupies 0..3)
   localparam logic [5:0] HDR_FIRST_POS       = 6'd4;
   localparam logic [5:0] HDR_LAST_POS        = 6'd39;
   localparam logic [5:0] HDR_BLOCK_COUNT_POS = 6'd24;
   localparam logic [5:0] HDR_BYTE_FIELD_POS  = 6'd12;
   localparam logic [5:0] HDR_WORD_CODE_BIAS  = 6'd5;
   localparam logic [5:0] HDR_BYTE_CODE_BIAS  = 6'd8;

   localparam logic [5:0] POINT_LAST_POS = 6'd8;
   localparam logic [5:0] TAIL_LAST_POS  = 6'd3;

   localparam logic [3:0] ROLLS_RESET = 4'd2;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [5:0]  field_code;
      logic [31:0] field_value;
      logic [7:0]  block_index;
      logic [3:0]  roll_index;
      logic [7:0]  point_index;
      logic [15:0] distance;
      logic [15:0] azimuth;
      logic [15:0] elevation;
      logic [7:0]  reflectivity;
      logic [15:0] point_spare;
      logic        packet_end;
   } rec_type;

   function automatic logic [7:0] sync_byte(input logic [1:0] idx);
      logic [7:0] val;
      unique case (idx)
         2'd0: val = 8'h55;
         2'd1: val = 8'haa;
         2'd2: val = 8'h5a;
         2'd3: val = 8'ha5;
         default: val = 8'h55;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/lidar_packet_deframer_top.sv
`timescale 1ns / 1ps
// Lidar packet deframer: parses a point-cloud packet one byte per item.
// Input channel (req_): one stream byte per item. Output channel (rsp_): at
// most one record per input byte: header, roll and tail fields, complete
// points, and sync errors. The tail record carries rsp_packet_end.
// csr_write_enable/csr_write_data set the rolls per data block (reset 2);
// write only while no packet is in flight.
// The record is registered (into the skid entry if rsp_stall holds the output) at the edge
// that accepts the byte completing it. One byte every cycle unless req_stall is high; the
// byte-wise parser state update is a single registered step.
// The output register is backed by one skid entry, so a byte is still taken
// while a record waits. req_stall rises only when the skid entry is full,
// i.e. after rsp_stall has held an output record and another arrived.
// Reset (synchronous) returns the parser to sync hunting, empties the output
// stages and restores the roll count to 2.
module lidar_packet_deframer_top
   import lpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_record_kind,
   output logic [5:0]  rsp_field_code,
   output logic [31:0] rsp_field_value,
   output logic [7:0]  rsp_block_index,
   output logic [3:0]  rsp_roll_index,
   output logic [7:0]  rsp_point_index,
   output logic [15:0] rsp_distance,
   output logic [15:0] rsp_azimuth,
   output logic [15:0] rsp_elevation,
   output logic [7:0]  rsp_reflectivity,
   output logic [15:0] rsp_point_spare,
   output logic        rsp_packet_end
);

   logic [3:0] rolls_ff, rolls_in;
   logic       req_accept;
   logic       rec_valid;
   rec_type    rec;
   rec_type    out_rec;

   always_comb begin
      rolls_in = csr_write_enable ? csr_write_data : rolls_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rolls_ff <= ROLLS_RESET;
      end else begin
         rolls_ff <= rolls_in;
      end
   end

   assign req_accept = req_valid && !req_stall;

   lpd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .byte_valid      (req_accept),
      .data_byte       (req_data_byte),
      .rolls_per_block (rolls_ff),
      .rec_valid       (rec_valid),
      .rec             (rec)
   );

   lpd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rec_valid),
      .in_rec    (rec),
      .in_full   (req_stall),
      .out_valid (rsp_valid),
      .out_rec   (out_rec),
      .out_stall (rsp_stall)
   );

   assign rsp_record_kind  = out_rec.record_kind;
   assign rsp_field_code   = out_rec.field_code;
   assign rsp_field_value  = out_rec.field_value;
   assign rsp_block_index  = out_rec.block_index;
   assign rsp_roll_index   = out_rec.roll_index;
   assign rsp_point_index  = out_rec.point_index;
   assign rsp_distance     = out_rec.distance;
   assign rsp_azimuth      = out_rec.azimuth;
   assign rsp_elevation    = out_rec.elevation;
   assign rsp_reflectivity = out_rec.reflectivity;
   assign rsp_point_spare  = out_rec.point_spare;
   assign rsp_packet_end   = out_rec.packet_end;

`ifndef NO_ASSERTIONS
   a_end_is_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_end |->
         rsp_record_kind == KIND_FIELD && rsp_field_code == CODE_TAIL)
      else $error("packet end on a record other than the tail");

   a_point_no_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == KIND_POINT |->
         rsp_field_code == CODE_NONE && rsp_field_value == 32'd0 && !rsp_packet_end)
      else $error("point record carries field data");
`endif

endmodule

// File: rtl/core/lpd_parser.sv
`timescale 1ns / 1ps

module lpd_parser
   import lpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] data_byte,
   input  logic [3:0] rolls_per_block,
   output logic       rec_valid,
   output rec_type    rec
);

   phase_type   state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  block_total_ff, block_total_in;
   logic [7:0]  block_ff, block_in;
   logic [3:0]  roll_ff, roll_in;
   logic [7:0]  pts_ff, pts_in;
   logic [7:0]  point_ff, point_in;
   logic        offset_ff, offset_in;
   logic [15:0] dist_ff, dist_in;
   logic [15:0] azim_ff, azim_in;
   logic [15:0] elev_ff, elev_in;
   logic [7:0]  refl_ff, refl_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= PH_HUNT;
         pos_ff         <= '0;
         acc_ff         <= '0;
         block_total_ff <= '0;
         block_ff       <= '0;
         roll_ff        <= '0;
         pts_ff         <= '0;
         point_ff       <= '0;
         offset_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         acc_ff         <= acc_in;
         block_total_ff <= block_total_in;
         block_ff       <= block_in;
         roll_ff        <= roll_in;
         pts_ff         <= pts_in;
         point_ff       <= point_in;
         offset_ff      <= offset_in;
      end
   end

   // point bytes are always written before they are shown
   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      azim_ff <= azim_in;
      elev_ff <= elev_in;
      refl_ff <= refl_in;
   end

   always_comb begin
      logic [5:0]  p;
      logic [4:0]  r_next;
      logic [8:0]  b_next;
      logic [8:0]  n_next;
      logic        next_roll;
      logic [31:0] tail_acc;

      state_in       = state_ff;
      pos_in         = pos_ff;
      acc_in         = acc_ff;
      block_total_in = block_total_ff;
      block_in       = block_ff;
      roll_in        = roll_ff;
      pts_in         = pts_ff;
      point_in       = point_ff;
      offset_in      = offset_ff;
      dist_in        = dist_ff;
      azim_in        = azim_ff;
      elev_in        = elev_ff;
      refl_in        = refl_ff;
      rec_valid      = 1'b0;
      rec            = '0;
      next_roll      = 1'b0;
      p              = pos_ff;
      r_next         = {1'b0, roll_ff} + 5'd1;
      b_next         = {1'b0, block_ff} + 9'd1;
      n_next         = {1'b0, point_ff} + 9'd1;
      tail_acc       = acc_ff;

      if (byte_valid) begin
         unique case (state_ff)
            PH_HUNT: begin
               p = {4'd0, pos_ff[1:0]};
               if (data_byte == sync_byte(p[1:0])) begin
                  if (p == TAIL_LAST_POS) begin
                     state_in = PH_HEAD;
                     pos_in   = HDR_FIRST_POS;
                     acc_in   = '0;
                  end else begin
                     pos_in = p + 6'd1;
                  end
               end else if (p != 6'd0) begin
                  // broken sync word: report it, the byte may restart the hunt
                  pos_in            = (data_byte == sync_byte(2'd0)) ? 6'd1 : 6'd0;
                  rec_valid         = 1'b1;
                  rec.record_kind   = KIND_ERROR;
                  rec.field_value   = {24'd0, data_byte};
               end
            end

            PH_HEAD: begin
               if (pos_ff < HDR_FIRST_POS || pos_ff > HDR_LAST_POS) begin
                  p = HDR_FIRST_POS;
               end
               if (p == HDR_BLOCK_COUNT_POS) begin
                  block_total_in = data_byte;
               end
               if (p == HDR_LAST_POS) begin
                  block_in = '0;
                  if (block_total_ff == 8'd0 || rolls_per_block == 4'd0) begin
                     state_in = PH_TAIL;
                     pos_in   = '0;
                     acc_in   = '0;
                  end else begin
                     roll_in   = '0;
                     offset_in = 1'b0;
                     state_in  = PH_COUNT;
                  end
               end else begin
                  pos_in = p + 6'd1;
               end
               if (p < HDR_BYTE_FIELD_POS) begin
                  if (!p[0]) begin
                     acc_in = {24'd0, data_byte};
                  end else begin
                     rec_valid       = 1'b1;
                     rec.field_code  = (p - HDR_WORD_CODE_BIAS) >> 1;
                     rec.field_value = {16'd0, data_byte, acc_ff[7:0]};
                  end
               end else begin
                  rec_valid       = 1'b1;
                  rec.field_code  = p - HDR_BYTE_CODE_BIAS;
                  rec.field_value = {24'd0, data_byte};
               end
            end

            PH_COUNT: begin
               rec_valid       = 1'b1;
               rec.field_code  = CODE_CHAN_COUNT;
               rec.field_value = {24'd0, data_byte};
               rec.block_index = block_ff;
               rec.roll_index  = roll_ff;
               pts_in          = data_byte;
               if (data_byte == 8'd0) begin
                  next_roll = 1'b1;
               end else begin
                  state_in = offset_ff ? PH_RETURN : PH_OFFSET;
               end
            end

            PH_OFFSET: begin
               rec_valid       = 1'b1;
               rec.field_code  = CODE_TIME_OFFSET;
               rec.field_value = {24'd0, data_byte};
               rec.block_index = block_ff;
               rec.roll_index  = roll_ff;
               offset_in       = 1'b1;
               state_in        = PH_RETURN;
            end

            PH_RETURN: begin
               rec_valid       = 1'b1;
               rec.field_code  = CODE_RETURN_NUM;
               rec.field_value = {24'd0, data_byte};
               rec.block_index = block_ff;
               rec.roll_index  = roll_ff;
               point_in        = '0;
               pos_in          = '0;
               state_in        = PH_POINT;
            end

            PH_POINT: begin
               if (pos_ff > POINT_LAST_POS) begin
                  p = '0;
               end
               unique case (p[3:0])
                  4'd0: dist_in = {8'd0, data_byte};
                  4'd1: dist_in = {data_byte, dist_ff[7:0]};
                  4'd2: azim_in = {8'd0, data_byte};
                  4'd3: azim_in = {data_byte, azim_ff[7:0]};
                  4'd4: elev_in = {8'd0, data_byte};
                  4'd5: elev_in = {data_byte, elev_ff[7:0]};
                  4'd6: refl_in = data_byte;
                  4'd7: acc_in  = {24'd0, data_byte};
                  default: ;
               endcase
               if (p < POINT_LAST_POS) begin
                  pos_in = p + 6'd1;
               end else begin
                  rec_valid        = 1'b1;
                  rec.record_kind  = KIND_POINT;
                  rec.block_index  = block_ff;
                  rec.roll_index   = roll_ff;
                  rec.point_index  = point_ff;
                  rec.distance     = dist_ff;
                  rec.azimuth      = azim_ff;
                  rec.elevation    = elev_ff;
                  rec.reflectivity = refl_ff;
                  rec.point_spare  = {data_byte, acc_ff[7:0]};
                  pos_in           = '0;
                  if (n_next >= {1'b0, pts_ff}) begin
                     point_in  = '0;
                     next_roll = 1'b1;
                  end else begin
                     point_in = n_next[7:0];
                  end
               end
            end

            PH_TAIL: begin
               p = {4'd0, pos_ff[1:0]};
               if (p == 6'd0) begin
                  tail_acc = {24'd0, data_byte};
               end else begin
                  tail_acc = acc_ff | ({24'd0, data_byte} << {p[1:0], 3'd0});
               end
               acc_in = tail_acc;
               if (p < TAIL_LAST_POS) begin
                  pos_in = p + 6'd1;
               end else begin
                  rec_valid       = 1'b1;
                  rec.field_code  = CODE_TAIL;
                  rec.field_value = tail_acc;
                  rec.packet_end  = 1'b1;
                  state_in        = PH_HUNT;
                  pos_in          = '0;
                  acc_in          = '0;
               end
            end

            default: begin
               state_in = PH_HUNT;
               pos_in   = '0;
            end
         endcase

         // roll / block boundary; the roll count compares against the live register
         if (next_roll) begin
            if (r_next >= {1'b0, rolls_per_block}) begin
               if (b_next >= {1'b0, block_total_ff}) begin
                  block_in = '0;
                  roll_in  = '0;
                  state_in = PH_TAIL;
                  pos_in   = '0;
                  acc_in   = '0;
               end else begin
                  block_in  = b_next[7:0];
                  roll_in   = '0;
                  offset_in = 1'b0;
                  state_in  = PH_COUNT;
               end
            end else begin
               roll_in  = r_next[3:0];
               state_in = PH_COUNT;
            end
         end
      end
   end

endmodule

// File: rtl/core/lpd_out_buf.sv
`timescale 1ns / 1ps

module lpd_out_buf
   import lpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rec_type in_rec,
   output logic    in_full,
   output logic    out_valid,
   output rec_type out_rec,
   input  logic    out_stall
);

   logic    main_valid_ff, main_valid_in;
   rec_type main_ff, main_in;
   logic    skid_valid_ff, skid_valid_in;
   rec_type skid_ff, skid_in;
   logic    main_free;

   assign main_free = !main_valid_ff || !out_stall;
   assign in_full   = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_rec   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_rec;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef NO_ASSERTIONS
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty output register");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !out_stall |=> main_valid_ff && !skid_valid_ff)
      else $error("skid entry not promoted after output taken");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid && main_valid_ff && out_stall |=> skid_valid_ff)
      else $error("item lost while output stalled");
`endif

endmodule
